// ===== rtl/bkrb_pkg.sv =====
package bkrb_pkg;

	// Key slots kept by the cell chain, and key fields carried in a report.
	localparam int unsigned KEY_SLOTS = 6;
	localparam int unsigned OUT_KEYS  = 6;

	localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
	localparam logic [15:0] ID_MOD_FIRST  = 16'h00E0;
	localparam logic [15:0] ID_MOD_LAST   = 16'h00E7;
	localparam logic [7:0]  CODE_EMPTY    = 8'h00;
	localparam logic [7:0]  CODE_ROLLOVER = 8'h01;

	typedef struct packed {
		logic [15:0] usage_page;
		logic [15:0] usage_id;
		logic        last_usage;
	} usage_item_t;

	typedef struct packed {
		logic [7:0] modifiers;
		logic [7:0] key_0;
		logic [7:0] key_1;
		logic [7:0] key_2;
		logic [7:0] key_3;
		logic [7:0] key_4;
		logic [7:0] key_5;
	} report_t;

	// Broadcast controls shared by every cell of the chain.
	typedef struct packed {
		logic step;
		logic clear;
		logic rollover;
	} cell_ctl_t;

endpackage

// ===== rtl/bkrb_slot_cell.sv =====
module bkrb_slot_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  bkrb_pkg::cell_ctl_t ctl,
	input  logic [7:0]         code,
	input  logic               carry_in,
	output logic               carry_out,
	output logic [7:0]         slot_next
);

	logic [7:0] slot_q;
	logic       empty;

	assign empty     = (slot_q == bkrb_pkg::CODE_EMPTY);
	// Pass the pending key on when this slot is already taken.
	assign carry_out = carry_in && !empty;

	always_comb begin
		if (ctl.rollover) begin
			slot_next = bkrb_pkg::CODE_ROLLOVER;
		end else if (carry_in && empty) begin
			slot_next = code;
		end else begin
			slot_next = slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= bkrb_pkg::CODE_EMPTY;
		end else if (ctl.step) begin
			slot_q <= ctl.clear ? bkrb_pkg::CODE_EMPTY : slot_next;
		end
	end

endmodule

// ===== rtl/boot_keyboard_report_builder_core.sv =====
// channel  | valid        | ready        | payload                    | beat
// ---------+--------------+--------------+----------------------------+---------------------
// usage in | item_valid   | item_ready   | item   (bkrb_pkg::usage_item_t) | one HID usage
// report   | report_valid | report_ready | report (bkrb_pkg::report_t)     | one boot report
//
// One usage beat is taken every cycle while item_ready is high; the report of
// a list leaves in the cycle after the beat marked last_usage is taken.
// The free-slot search ripples through the row of slot cells in the take cycle.
// Reset clears the modifier byte, every slot and the report register.
// item_ready drops only while a finished report waits and report_ready is low.
module boot_keyboard_report_builder_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  bkrb_pkg::usage_item_t item,
	output logic                  report_valid,
	input  logic                  report_ready,
	output bkrb_pkg::report_t     report
);

	logic                  take;
	logic                  on_page;
	logic                  is_mod;
	logic                  is_key;
	logic [7:0]            mod_q;
	logic [7:0]            mod_next;
	logic [7:0]            mod_hit;
	logic [bkrb_pkg::KEY_SLOTS:0] carry;
	logic [7:0]            slot_next [bkrb_pkg::KEY_SLOTS];
	logic [7:0]            keys_w    [bkrb_pkg::OUT_KEYS];
	bkrb_pkg::cell_ctl_t   ctl;
	bkrb_pkg::report_t     report_d;
	logic                  report_valid_q;
	bkrb_pkg::report_t     report_q;

	// The report register parts the two sides: take a usage unless a report
	// is stuck waiting.
	assign item_ready = !report_valid_q || report_ready;
	assign take       = item_valid && item_ready;

	// Classify the usage: keyboard page, modifier range or ordinary key.
	assign on_page = (item.usage_page == bkrb_pkg::PAGE_KEYBOARD);
	assign is_mod  = on_page && (item.usage_id >= bkrb_pkg::ID_MOD_FIRST)
		&& (item.usage_id <= bkrb_pkg::ID_MOD_LAST);
	assign is_key  = on_page && !is_mod;

	assign mod_hit  = is_mod ? (8'h01 << item.usage_id[2:0]) : 8'h00;
	assign mod_next = mod_q | mod_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= 8'h00;
		end else if (take) begin
			mod_q <= item.last_usage ? 8'h00 : mod_next;
		end
	end

	// Drive the key into the head of the chain; a carry out of the tail means
	// every slot was full, so flip the whole row to rollover.
	assign carry[0]     = is_key;
	assign ctl.step     = take;
	assign ctl.clear    = item.last_usage;
	assign ctl.rollover = carry[bkrb_pkg::KEY_SLOTS];

	for (genvar i = 0; i < bkrb_pkg::KEY_SLOTS; i++) begin : g_cell
		bkrb_slot_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.code      (item.usage_id[7:0]),
			.carry_in  (carry[i]),
			.carry_out (carry[i+1]),
			.slot_next (slot_next[i])
		);
	end

	// Map slots onto the report's key fields; fields past the chain read empty.
	for (genvar j = 0; j < bkrb_pkg::OUT_KEYS; j++) begin : g_key
		if (j < bkrb_pkg::KEY_SLOTS) begin : g_live
			assign keys_w[j] = slot_next[j];
		end else begin : g_none
			assign keys_w[j] = bkrb_pkg::CODE_EMPTY;
		end
	end

	assign report_d.modifiers = mod_next;
	assign report_d.key_0     = keys_w[0];
	assign report_d.key_1     = keys_w[1];
	assign report_d.key_2     = keys_w[2];
	assign report_d.key_3     = keys_w[3];
	assign report_d.key_4     = keys_w[4];
	assign report_d.key_5     = keys_w[5];

	// Hold the report until the sink takes it; load on the last usage beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (take && item.last_usage) begin
			report_valid_q <= 1'b1;
		end else if (report_ready) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_q <= '0;
		end else if (take && item.last_usage) begin
			report_q <= report_d;
		end
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	import bkrb_pkg::*;

	// Run limit in clock cycles. The slowest correct run is about 1200 usage beats,
	// each followed by a drawn idle gap, and a few hundred reports, each held for
	// a drawn stall. That is far below this limit, so it leaves wide margin.
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned RANDOM_BEATS = 1150;
	localparam int unsigned DRAIN_CYCLES = 20;

	// One queued usage beat, with the idle cycles the driver waits after it.
	typedef struct {
		usage_item_t beat;
		int unsigned gap;
	} pending_usage_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	usage_item_t usage_beat = '0;
	logic        report_valid;
	logic        report_ready = 1'b0;
	report_t     report_beat;

	// Stimulus waiting for the driver, and the boot reports that the accepted
	// usages must produce, oldest first.
	pending_usage_t pending_usages[$];
	report_t        expected_reports[$];

	// Predicted report under construction: modifier byte and key slots.
	logic [7:0] held_modifiers;
	logic [7:0] held_slots [KEY_SLOTS];

	int unsigned usage_gap;
	int unsigned ready_hold;
	int unsigned report_count;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	boot_keyboard_report_builder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (usage_beat),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report_beat)
	);

	// 20 ns period: high for 10, low for 10.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("report %0d field %s: got 0x%02h, expected 0x%02h",
				report_count, name, got, want));
		end
	endtask

	task automatic clear_keymap();
		held_modifiers = '0;
		foreach (held_slots[s]) held_slots[s] = CODE_EMPTY;
	endtask

	// Fold one accepted usage into the predicted report. On a beat marked last,
	// queue the finished report and start the next list from empty.
	task automatic apply_usage(input usage_item_t u);
		int         free_slot;
		int unsigned mod_bit;
		logic [7:0] keys [OUT_KEYS];
		report_t    done;
		free_slot = -1;
		if (u.usage_page == PAGE_KEYBOARD) begin
			if (u.usage_id >= ID_MOD_FIRST && u.usage_id <= ID_MOD_LAST) begin
				mod_bit = u.usage_id - ID_MOD_FIRST;
				held_modifiers[mod_bit] = 1'b1;
			end else begin
				// Take the first empty slot; a stored code of zero leaves it empty.
				for (int s = 0; s < KEY_SLOTS; s++) begin
					if (free_slot < 0 && held_slots[s] == CODE_EMPTY) free_slot = s;
				end
				if (free_slot >= 0) begin
					held_slots[free_slot] = u.usage_id[7:0];
				end else begin
					// No room: the whole report goes to error rollover.
					foreach (held_slots[s]) held_slots[s] = CODE_ROLLOVER;
				end
			end
		end
		if (u.last_usage) begin
			for (int k = 0; k < OUT_KEYS; k++) begin
				keys[k] = (k < KEY_SLOTS) ? held_slots[k] : CODE_EMPTY;
			end
			done.modifiers = held_modifiers;
			done.key_0     = keys[0];
			done.key_1     = keys[1];
			done.key_2     = keys[2];
			done.key_3     = keys[3];
			done.key_4     = keys[4];
			done.key_5     = keys[5];
			expected_reports.push_back(done);
			clear_keymap();
		end
	endtask

	// Queue a usage beat. The idle mode depends on where the beat falls, so the
	// run has stretches with no gaps, with sparse gaps, and with full gaps.
	task automatic queue_usage(input logic [15:0] page, input logic [15:0] id,
			input logic last);
		pending_usage_t p;
		p.beat.usage_page = page;
		p.beat.usage_id   = id;
		p.beat.last_usage = last;
		case ((pending_usages.size() / 60) % 4)
			0:       p.gap = 0;
			2:       p.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
			default: p.gap = $urandom_range(0, 16);
		endcase
		pending_usages.push_back(p);
	endtask

	// Draw one usage with a mix weighted toward real key presses, so lists reach
	// full slots and rollover, with modifiers, odd ids and foreign pages mixed in.
	task automatic queue_random_usage(input logic last, inout int unsigned counted);
		logic [15:0] page;
		logic [15:0] id;
		page = PAGE_KEYBOARD;
		id   = 16'($urandom);
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8: id = 16'($urandom_range(8'h04, 8'hA4));
			9, 10, 11, 12:             id = ID_MOD_FIRST + 16'($urandom_range(0, 7));
			13:                        id[7:0] = CODE_EMPTY;
			14, 15:                    ;
			16, 17:                    page = 16'($urandom);
			18: begin
				// Near miss on the page: one bit off the keyboard page.
				page = PAGE_KEYBOARD ^ (16'h1 << $urandom_range(0, 15));
				id   = 16'($urandom_range(8'h04, 8'hA4));
			end
			default:                   id = 16'h0000;
		endcase
		counted++;
		queue_usage(page, id, last);
	endtask

	// Driver: present queued usages, hold each until it is taken, then idle for
	// its drawn gap. Predict at the edge where the beat is accepted.
	always @(posedge clk or negedge arst_n) begin : usage_driver
		pending_usage_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			usage_beat <= '0;
			usage_gap  <= 0;
		end else begin
			if (item_valid && item_ready) apply_usage(usage_beat);
			// Hold the beat while it waits; otherwise idle or advance.
			if (!(item_valid && !item_ready)) begin
				if (usage_gap != 0) begin
					usage_gap  <= usage_gap - 1;
					item_valid <= 1'b0;
				end else if (pending_usages.size() != 0) begin
					nxt = pending_usages.pop_front();
					usage_beat <= nxt.beat;
					usage_gap  <= nxt.gap;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: take each report beat, check it against the oldest expectation,
	// then stall the next report for a drawn number of valid cycles. Every third
	// stretch of 30 reports runs with ready held high.
	always @(posedge clk or negedge arst_n) begin : report_monitor
		report_t     want;
		int unsigned stall;
		if (!arst_n) begin
			report_ready <= 1'b0;
			ready_hold   <= 0;
			report_count <= 0;
		end else if (report_valid && report_ready) begin
			if (expected_reports.size() == 0) begin
				flag_mismatch($sformatf("report %0d arrived with no list pending",
					report_count));
			end else begin
				want = expected_reports.pop_front();
				check_field("modifiers", report_beat.modifiers, want.modifiers);
				check_field("key_0", report_beat.key_0, want.key_0);
				check_field("key_1", report_beat.key_1, want.key_1);
				check_field("key_2", report_beat.key_2, want.key_2);
				check_field("key_3", report_beat.key_3, want.key_3);
				check_field("key_4", report_beat.key_4, want.key_4);
				check_field("key_5", report_beat.key_5, want.key_5);
			end
			stall = ((report_count / 30) % 3 == 1) ? 0 : $urandom_range(0, 16);
			ready_hold   <= stall;
			report_ready <= (stall == 0);
			report_count <= report_count + 1;
		end else if (ready_hold != 0) begin
			// Count the stall down only while a report is waiting, so it backs up
			// the block and pulls item_ready low.
			if (report_valid) ready_hold <= ready_hold - 1;
			report_ready <= 1'b0;
		end else begin
			report_ready <= 1'b1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned counted;
		int unsigned list_len;
		counted = 0;
		clear_keymap();

		// Single key, closed at once.
		queue_usage(PAGE_KEYBOARD, 16'h0004, 1'b1);
		// Every modifier, closed by a usage from a foreign page that is ignored.
		for (int m = 0; m < 8; m++) queue_usage(PAGE_KEYBOARD, ID_MOD_FIRST + 16'(m), 1'b0);
		queue_usage(16'hFFFF, 16'hFFFF, 1'b1);
		// Ids just outside the modifier range go to key slots.
		queue_usage(PAGE_KEYBOARD, ID_MOD_FIRST - 16'h1, 1'b0);
		queue_usage(PAGE_KEYBOARD, ID_MOD_LAST + 16'h1, 1'b1);
		// Wide ids keep their low byte; a zero low byte leaves the slot empty;
		// then the slots fill, overflow into rollover, and rollover sticks.
		queue_usage(PAGE_KEYBOARD, 16'hFFFF, 1'b0);
		queue_usage(PAGE_KEYBOARD, 16'h01E0, 1'b0);
		queue_usage(PAGE_KEYBOARD, 16'h0100, 1'b0);
		queue_usage(PAGE_KEYBOARD, 16'h0000, 1'b0);
		for (int k = 5; k <= 8; k++) queue_usage(PAGE_KEYBOARD, 16'(k), 1'b0);
		queue_usage(PAGE_KEYBOARD, 16'h0009, 1'b0);
		queue_usage(PAGE_KEYBOARD, 16'h000A, 1'b1);
		// Neighboring pages are ignored, giving an empty report.
		queue_usage(16'h0006, 16'h0004, 1'b0);
		queue_usage(16'h8007, 16'h0004, 1'b0);
		queue_usage(16'h0000, 16'h0000, 1'b1);

		// Random lists: mostly short, about a quarter long enough to overflow.
		while (counted < RANDOM_BEATS) begin
			list_len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14)
				: $urandom_range(1, 7);
			for (int n = 1; n <= list_len; n++) queue_random_usage(n == list_len, counted);
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Drain: everything sent, every report back, then a short quiet tail to
		// catch any stray report.
		while (pending_usages.size() != 0 || item_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
